### rtl/hmv_pkg.sv
// Shared types, codes and score arithmetic for the second-order Viterbi decoder.
`default_nettype none
package hmv_pkg;

  typedef logic signed [15:0] val_t;
  typedef logic signed [23:0] score_t;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_TRANS = 2'd0;
  localparam logic [1:0] KIND_PRIOR = 2'd1;
  localparam logic [1:0] KIND_EMIT  = 2'd2;
  localparam logic [1:0] KIND_SYM   = 2'd3;

  // Status codes on the result channel
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_TRUNC = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  localparam val_t   VAL_ZERO   = 16'sh8000;
  localparam score_t SCORE_ZERO = 24'sh800000;
  localparam score_t SCORE_MIN  = 24'sh800001;
  localparam score_t SCORE_MAX  = 24'sh7fffff;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_A,
    ST_INIT_B,
    ST_INIT_C,
    ST_INIT_D,
    ST_ADV_RD,
    ST_ADV_DRAIN,
    ST_ADV_WR,
    ST_POST,
    ST_SRCH_RD,
    ST_SRCH_DRAIN,
    ST_BT_TOP,
    ST_BT_RD,
    ST_BT_WAIT,
    ST_OUT_RD,
    ST_OUT_SHOW
  } state_t;

  // Control of the shared add-compare-select unit
  typedef struct packed {
    logic en;     // update the accumulator
    logic load;   // take the sum unconditionally
    logic first;  // first candidate of a compare run
  } acs_ctl_t;

  // Table value to score; log of zero maps to the score zero code
  function automatic score_t lg(val_t v);
    score_t r;
    if (v == VAL_ZERO) r = SCORE_ZERO;
    else               r = 24'(v);
    return r;
  endfunction

  // Saturating score add; log of zero absorbs
  function automatic score_t sadd(score_t a, score_t b);
    logic signed [24:0] s;
    score_t r;
    s = {a[23], a} + {b[23], b};
    if (a == SCORE_ZERO || b == SCORE_ZERO) r = SCORE_ZERO;
    else if (s > 25'sd8388607)              r = SCORE_MAX;
    else if (s < -25'sd8388607)             r = SCORE_MIN;
    else                                    r = s[23:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/hmv_if.sv
// Valid/ready channel interfaces for symbol/table beats and path beats.
`default_nettype none
interface hmv_in_if;
  import hmv_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [10:0] table_index;
  val_t       log_value;
  logic [7:0] symbol;
  logic       seq_last;
  modport source (output valid, kind, table_index, log_value, symbol, seq_last, input ready);
  modport sink   (input valid, kind, table_index, log_value, symbol, seq_last, output ready);
endinterface

interface hmv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] path_state;
  logic       path_last;
  logic [1:0] status;
  modport source (output valid, path_state, path_last, status, input ready);
  modport sink   (input valid, path_state, path_last, status, output ready);
endinterface
`default_nettype wire

### rtl/hmv_acs.sv
// Shared saturating add / compare / select unit with best-score accumulator.
`default_nettype none
module hmv_acs #(
  parameter int IDX_W = 6
) (
  input  wire                   clk,
  input  wire hmv_pkg::acs_ctl_t ctl,
  input  wire hmv_pkg::score_t  op_a,
  input  wire hmv_pkg::score_t  op_b,
  input  wire logic [IDX_W-1:0] idx,
  output hmv_pkg::score_t       sum,
  output hmv_pkg::score_t       best_r,
  output logic [IDX_W-1:0]      bi_r
);
  import hmv_pkg::*;

  assign sum = sadd(op_a, op_b);

  // Strict compare: ties keep the lower index
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.load) begin
        best_r <= sum;
      end else if (ctl.first || sum > best_r) begin
        best_r <= sum;
        bi_r   <= idx;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/second_order_hmm_viterbi.sv
// Top level: table memories, score banks, backpointers and the decode sequencer.
// Second-order Viterbi decoder. Table beats (transition, prior, emission) are written to the
// table memories while idle. A symbol beat is worked through one shared add-compare-select
// unit: the first symbol is only stored, the second seeds the pair scores, and each later
// symbol takes one predecessor per cycle through the score and transition memory ports, with
// a drain and a write step after each pair. On the beat marked seq_last the block then scans
// the N*N final scores, walks the backpointers and sends one path beat per position; a
// sequence under two symbols gets one short beat. ready stays low throughout. No clearing pass.
`default_nettype none
module second_order_hmm_viterbi #(
  parameter int NUM_STATES  = 8,
  parameter int NUM_SYMBOLS = 256,
  parameter int MAX_LEN     = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  hmv_in_if.sink     in_ch,
  hmv_out_if.source  out_ch
);
  import hmv_pkg::*;

  localparam int N   = NUM_STATES;
  localparam int NP  = N * N;
  localparam int TD  = NP * N;
  localparam int ED  = N * NUM_SYMBOLS;
  localparam int BD  = MAX_LEN * NP;
  localparam int SW  = $clog2(N);
  localparam int PW  = $clog2(NP);
  localparam int TW  = $clog2(TD);
  localparam int EW  = $clog2(ED);
  localparam int BW  = $clog2(BD);
  localparam int LW  = $clog2(MAX_LEN + 2);
  localparam int KW  = $clog2(MAX_LEN);

  function automatic logic [PW-1:0] pidx(logic [SW-1:0] x, logic [SW-1:0] y);
    return PW'(x * N + y);
  endfunction

  // Memories
  val_t            trans_mem [TD];
  val_t            prior_mem [NP];
  val_t            emit_mem  [ED];
  score_t          score_mem [2**(PW+1)];
  logic [2*SW-1:0] bp_mem    [BD];
  logic [2:0]      path_mem  [MAX_LEN];

  // Registers
  state_t          st_r, st_nxt;
  logic [LW-1:0]   pos_r, pos_nxt;
  logic [LW-1:0]   t_r, t_nxt;
  logic [7:0]      first_r, first_nxt;
  logic [7:0]      sym_r, sym_nxt;
  logic            last_r, last_nxt;
  logic [SW-1:0]   a_r, a_nxt, b_r, b_nxt, i_r, i_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [2*SW-1:0] q_r, q_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            short_r, short_nxt;
  score_t          e1_r, e1_nxt;
  logic            vld_r;
  logic [2*SW-1:0] idxd_r;

  // Read ports
  val_t            trans_rd_r, prior_rd_r, emit_rd_r;
  logic            emit_oob_r;
  score_t          score_rd_r;
  logic [2*SW-1:0] bp_rd_r;
  logic [2:0]      path_rd_r;

  // Combinational control
  logic [TW-1:0]   trans_ra;
  logic [EW-1:0]   emit_ra;
  logic            emit_oob;
  logic [SW-1:0]   emit_st;
  logic [7:0]      emit_sym;
  logic [PW:0]     score_ra, score_wa;
  logic            score_we;
  logic [BW-1:0]   bp_ra, bp_wa;
  logic            bp_we;
  logic [KW-1:0]   path_ra, path_wa;
  logic            path_we;
  logic [2:0]      path_wd;
  logic            iss;
  logic [2*SW-1:0] iss_idx;
  acs_ctl_t        acs_ctl;
  score_t          op_a, op_b, acs_sum, best_r, emit_lg;
  logic [2*SW-1:0] bi_r;
  logic            in_fire, last_pair;
  logic [LW-1:0]   len_c;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE);
  assign last_pair = (a_r == SW'(N - 1)) && (b_r == SW'(N - 1));
  assign emit_lg   = emit_oob_r ? SCORE_ZERO : lg(emit_rd_r);
  assign len_c     = (pos_r > LW'(MAX_LEN)) ? LW'(MAX_LEN) : pos_r;

  hmv_acs #(.IDX_W(2 * SW)) u_acs (
    .clk    (clk),
    .ctl    (acs_ctl),
    .op_a   (op_a),
    .op_b   (op_b),
    .idx    (idxd_r),
    .sum    (acs_sum),
    .best_r (best_r),
    .bi_r   (bi_r)
  );

  // Table writes and memory ports
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.kind == KIND_TRANS && 32'(in_ch.table_index) < TD)
      trans_mem[TW'(in_ch.table_index)] <= in_ch.log_value;
    if (in_fire && in_ch.kind == KIND_PRIOR && 32'(in_ch.table_index) < NP)
      prior_mem[PW'(in_ch.table_index)] <= in_ch.log_value;
    if (in_fire && in_ch.kind == KIND_EMIT && 32'(in_ch.table_index) < ED)
      emit_mem[EW'(in_ch.table_index)] <= in_ch.log_value;
    if (score_we) score_mem[score_wa] <= acs_sum;
    if (bp_we)    bp_mem[bp_wa]       <= bi_r;
    if (path_we)  path_mem[path_wa]   <= path_wd;
    trans_rd_r <= trans_mem[trans_ra];
    prior_rd_r <= prior_mem[pidx(a_r, b_r)];
    emit_rd_r  <= emit_mem[emit_ra];
    emit_oob_r <= emit_oob;
    score_rd_r <= score_mem[score_ra];
    bp_rd_r    <= bp_mem[bp_ra];
    path_rd_r  <= path_mem[path_ra];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      pos_r   <= '0;
      first_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
      vld_r   <= iss;
    end
  end

  // Sequencing payload
  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    sym_r    <= sym_nxt;
    last_r   <= last_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    q_r      <= q_nxt;
    len_r    <= len_nxt;
    status_r <= status_nxt;
    short_r  <= short_nxt;
    e1_r     <= e1_nxt;
    idxd_r   <= iss_idx;
  end

  // Next state and datapath control
  always_comb begin
    st_nxt     = st_r;
    pos_nxt    = pos_r;
    t_nxt      = t_r;
    first_nxt  = first_r;
    sym_nxt    = sym_r;
    last_nxt   = last_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    q_nxt      = q_r;
    len_nxt    = len_r;
    status_nxt = status_r;
    short_nxt  = short_r;
    e1_nxt     = e1_r;
    emit_st    = b_r;
    emit_sym   = sym_r;
    trans_ra   = TW'((32'(pidx(i_r, a_r)) * N) + 32'(b_r));
    score_ra   = {~t_r[0], pidx(i_r, a_r)};
    score_we   = 1'b0;
    score_wa   = {t_r[0], pidx(a_r, b_r)};
    bp_ra      = BW'((32'(k_r) + 1) * NP + 32'(pidx(q_r[2*SW-1:SW], q_r[SW-1:0])));
    bp_wa      = BW'(32'(t_r) * NP + 32'(pidx(a_r, b_r)));
    bp_we      = 1'b0;
    path_ra    = k_r;
    path_wa    = k_r;
    path_we    = 1'b0;
    path_wd    = 3'(bp_rd_r[SW-1:0]);
    iss        = 1'b0;
    iss_idx    = {i_r, a_r};
    acs_ctl    = '0;
    op_a       = score_rd_r;
    op_b       = lg(trans_rd_r);

    unique case (st_r)
      ST_IDLE: begin
        if (in_fire && in_ch.kind == KIND_SYM) begin
          sym_nxt  = in_ch.symbol;
          last_nxt = in_ch.seq_last;
          t_nxt    = pos_r;
          a_nxt    = '0;
          b_nxt    = '0;
          i_nxt    = '0;
          if (pos_r < LW'(MAX_LEN)) begin
            pos_nxt = pos_r + LW'(1);
            if (pos_r == '0) begin
              first_nxt = in_ch.symbol;
              st_nxt    = ST_POST;
            end else if (pos_r == LW'(1)) begin
              st_nxt = ST_INIT_A;
            end else begin
              st_nxt = ST_ADV_RD;
            end
          end else begin
            pos_nxt = LW'(MAX_LEN + 1);
            st_nxt  = ST_POST;
          end
        end
      end
      // Seed pair (a,b): prior plus emissions of both states
      ST_INIT_A: begin
        emit_st  = a_r;
        emit_sym = first_r;
        st_nxt   = ST_INIT_B;
      end
      ST_INIT_B: begin
        e1_nxt = emit_lg;
        st_nxt = ST_INIT_C;
      end
      ST_INIT_C: begin
        op_a    = e1_r;
        op_b    = emit_lg;
        acs_ctl = '{en: 1'b1, load: 1'b1, first: 1'b0};
        st_nxt  = ST_INIT_D;
      end
      ST_INIT_D: begin
        op_a     = lg(prior_rd_r);
        op_b     = best_r;
        score_we = 1'b1;
        score_wa = {1'b1, pidx(a_r, b_r)};
        b_nxt    = b_r + SW'(1);
        if (b_r == SW'(N - 1)) begin
          b_nxt = '0;
          a_nxt = a_r + SW'(1);
        end
        st_nxt = last_pair ? ST_POST : ST_INIT_A;
      end
      // One predecessor (i,a) per cycle into the shared unit
      ST_ADV_RD: begin
        iss   = 1'b1;
        i_nxt = i_r + SW'(1);
        if (i_r == SW'(N - 1)) st_nxt = ST_ADV_DRAIN;
        acs_ctl = '{en: vld_r, load: 1'b0, first: (idxd_r[2*SW-1:SW] == '0)};
      end
      ST_ADV_DRAIN: begin
        acs_ctl = '{en: vld_r, load: 1'b0, first: (idxd_r[2*SW-1:SW] == '0)};
        st_nxt  = ST_ADV_WR;
      end
      ST_ADV_WR: begin
        op_a     = best_r;
        op_b     = emit_lg;
        score_we = 1'b1;
        bp_we    = 1'b1;
        i_nxt    = '0;
        b_nxt    = b_r + SW'(1);
        if (b_r == SW'(N - 1)) begin
          b_nxt = '0;
          a_nxt = a_r + SW'(1);
        end
        st_nxt = last_pair ? ST_POST : ST_ADV_RD;
      end
      ST_POST: begin
        a_nxt = '0;
        b_nxt = '0;
        k_nxt = '0;
        if (last_r) begin
          pos_nxt    = '0;
          len_nxt    = len_c;
          status_nxt = (pos_r > LW'(MAX_LEN)) ? STATUS_TRUNC : STATUS_OK;
          short_nxt  = 1'b0;
          if (len_c < LW'(2)) begin
            len_nxt    = LW'(1);
            status_nxt = STATUS_SHORT;
            short_nxt  = 1'b1;
            st_nxt     = ST_OUT_RD;
          end else begin
            st_nxt = ST_SRCH_RD;
          end
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      // Best final pair over the last score bank
      ST_SRCH_RD: begin
        score_ra = {~len_r[0], pidx(a_r, b_r)};
        iss      = 1'b1;
        iss_idx  = {a_r, b_r};
        op_b     = '0;
        acs_ctl  = '{en: vld_r, load: 1'b0, first: (idxd_r == '0)};
        b_nxt    = b_r + SW'(1);
        if (b_r == SW'(N - 1)) begin
          b_nxt = '0;
          a_nxt = a_r + SW'(1);
        end
        if (last_pair) st_nxt = ST_SRCH_DRAIN;
      end
      ST_SRCH_DRAIN: begin
        op_b    = '0;
        acs_ctl = '{en: vld_r, load: 1'b0, first: (idxd_r == '0)};
        st_nxt  = ST_BT_TOP;
      end
      ST_BT_TOP: begin
        q_nxt   = bi_r;
        path_we = 1'b1;
        path_wa = KW'(32'(len_r) - 1);
        path_wd = 3'(bi_r[SW-1:0]);
        k_nxt   = KW'(32'(len_r) - 2);
        st_nxt  = (len_r == LW'(2)) ? ST_OUT_RD : ST_BT_RD;
        if (len_r == LW'(2)) st_nxt = ST_BT_WAIT;
      end
      // Backtrack: position k from the backpointer of k+1
      ST_BT_RD: begin
        st_nxt = ST_BT_WAIT;
      end
      ST_BT_WAIT: begin
        if (k_r == '0) begin
          path_we = 1'b1;
          path_wa = '0;
          path_wd = 3'(q_r[2*SW-1:SW]);
          st_nxt  = ST_OUT_RD;
        end else begin
          q_nxt   = bp_rd_r;
          path_we = 1'b1;
          k_nxt   = k_r - KW'(1);
          st_nxt  = (k_r == KW'(1)) ? ST_BT_WAIT : ST_BT_RD;
        end
      end
      ST_OUT_RD: begin
        st_nxt = ST_OUT_SHOW;
      end
      ST_OUT_SHOW: begin
        if (out_ch.ready) begin
          if (32'(k_r) == 32'(len_r) - 1) begin
            st_nxt = ST_IDLE;
          end else begin
            k_nxt  = k_r + KW'(1);
            st_nxt = ST_OUT_RD;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    emit_ra  = EW'(32'(emit_st) * NUM_SYMBOLS + 32'(emit_sym));
    emit_oob = (32'(emit_sym) >= NUM_SYMBOLS);
  end

  // Result beat straight from registers
  assign out_ch.valid      = (st_r == ST_OUT_SHOW);
  assign out_ch.path_state = short_r ? 3'd0 : path_rd_r;
  assign out_ch.path_last  = (32'(k_r) == 32'(len_r) - 1);
  assign out_ch.status     = status_r;

  // Checks
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.path_last |=> in_ch.ready)
    else $error("block not ready after final path beat");
  a_adv_pos: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_ADV_WR |-> t_r >= LW'(2) && t_r < LW'(MAX_LEN))
    else $error("advance at illegal position");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LW'(MAX_LEN + 1))
    else $error("position beyond overflow mark");
  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && short_r |-> out_ch.path_last && out_ch.status == STATUS_SHORT)
    else $error("short sequence beat malformed");

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the second-order Viterbi decoder: table loads, symbol streams, paths.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hmv_pkg::*;

  localparam int NS   = 8;
  localparam int NSYM = 256;
  localparam int MAXL = 64;
  localparam int NP   = NS * NS;
  localparam int TRANSD = NP * NS;

  typedef struct {
    logic [2:0] st;
    logic       lst;
    logic [1:0] stat;
  } path_beat_t;

  // One row of the directed stimulus; typed rows carry their one expected beat
  typedef struct {
    logic [1:0]  kind;
    logic [10:0] idx;
    val_t        val;
    logic [7:0]  sym;
    logic        last;
    bit          typed;
    path_beat_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hmv_in_if  in_ch ();
  hmv_out_if out_ch ();

  second_order_hmm_viterbi DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  val_t       trans_lp [TRANSD];
  val_t       prior_lp [NP];
  val_t       emit_lp  [NS * NSYM];
  score_t     pair_sc  [2][NP];
  logic [5:0] back_ptr [MAXL][NP];
  int         seq_pos;
  logic [7:0] first_sym;

  path_beat_t path_q[$];
  int         errors;
  int         tx_idle, rx_idle;
  bit         hold_req;
  int         hold_left;

  logic [7:0] sym_pool [6] = '{8'd0, 8'd255, 8'h55, 8'haa, 8'd1, 8'd2};

  function automatic score_t log_to_score(val_t v);
    if (v == VAL_ZERO) return SCORE_ZERO;
    return score_t'(v);
  endfunction

  // Saturating add where log of zero wins
  function automatic score_t score_add(score_t a, score_t b);
    int s;
    if (a == SCORE_ZERO || b == SCORE_ZERO) return SCORE_ZERO;
    s = int'(a) + int'(b);
    if (s > 8388607) s = 8388607;
    if (s < -8388607) s = -8388607;
    return score_t'(s);
  endfunction

  function automatic score_t emit_score(int st, logic [7:0] s);
    return log_to_score(emit_lp[st * NSYM + s]);
  endfunction

  // Walks one accepted beat through the decoder and queues the path it produces
  function automatic void viterbi_predict(logic [1:0] kind, logic [10:0] idx, val_t v,
                                          logic [7:0] s, logic last, bit keep);
    int len, q, k, a, b, bi, p;
    logic [1:0] stat;
    score_t best, cand;
    int path [MAXL];
    path_beat_t pb;
    case (kind)
      KIND_TRANS: begin
        if (idx < TRANSD) trans_lp[idx] = v;
        return;
      end
      KIND_PRIOR: begin
        if (idx < NP) prior_lp[idx] = v;
        return;
      end
      KIND_EMIT: begin
        emit_lp[idx] = v;
        return;
      end
      default: ;
    endcase
    if (seq_pos < MAXL) begin
      if (seq_pos == 0) begin
        first_sym = s;
      end else if (seq_pos == 1) begin
        for (int i = 0; i < NS; i++)
          for (int j = 0; j < NS; j++)
            pair_sc[1][i*NS+j] = score_add(log_to_score(prior_lp[i*NS+j]),
              score_add(emit_score(i, first_sym), emit_score(j, s)));
      end else begin
        for (int j = 0; j < NP; j++) begin
          a = j / NS;
          b = j % NS;
          bi = 0;
          best = '0;
          for (int i = 0; i < NS; i++) begin
            p = i * NS + a;
            cand = score_add(pair_sc[(seq_pos-1)&1][p], log_to_score(trans_lp[p*NS+b]));
            if (i == 0 || cand > best) begin
              best = cand;
              bi = i;
            end
          end
          pair_sc[seq_pos&1][j] = score_add(best, emit_score(b, s));
          back_ptr[seq_pos][j] = 6'(bi * NS + a);
        end
      end
      seq_pos++;
    end else begin
      seq_pos = MAXL + 1;
    end
    if (!last) return;
    len = (seq_pos > MAXL) ? MAXL : seq_pos;
    stat = (seq_pos > MAXL) ? STATUS_TRUNC : STATUS_OK;
    seq_pos = 0;
    if (!keep) return;
    if (len < 2) begin
      pb.st = 3'd0; pb.lst = 1'b1; pb.stat = STATUS_SHORT;
      path_q.push_back(pb);
      return;
    end
    // Best final pair, then backtrack
    q = 0;
    for (int j = 0; j < NP; j++)
      if (j == 0 || pair_sc[(len-1)&1][j] > pair_sc[(len-1)&1][q]) q = j;
    path[len-1] = q % NS;
    for (k = len - 2; k >= 1; k--) begin
      q = back_ptr[k+1][q];
      path[k] = q % NS;
    end
    path[0] = q / NS;
    for (k = 0; k < len; k++) begin
      pb.st = 3'(path[k]); pb.lst = (k == len - 1); pb.stat = stat;
      path_q.push_back(pb);
    end
  endfunction

  // Offers one beat, waits for acceptance, then predicts
  task automatic send_beat(logic [1:0] kind, logic [10:0] idx, val_t v, logic [7:0] s,
                           logic last, bit typed = 0, path_beat_t want = '{0, 0, 0});
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.kind = kind;
    in_ch.table_index = idx;
    in_ch.log_value = v;
    in_ch.symbol = s;
    in_ch.seq_last = last;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) path_q.push_back(want);
    viterbi_predict(kind, idx, v, s, last, !typed);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic val_t rand_val();
    case ($urandom_range(9))
      0: return VAL_ZERO;
      1: return 16'sd32767;
      2: return -16'sd32767;
      default: return val_t'(int'($urandom_range(4095)) - 2048);
    endcase
  endfunction

  function automatic logic [7:0] pool_sym();
    return sym_pool[$urandom_range(5)];
  endfunction

  // Loads every table entry that a symbol of the pool can read
  task automatic load_tables(bit zeros);
    for (int i = 0; i < TRANSD; i++)
      send_beat(KIND_TRANS, 11'(i), zeros ? val_t'(0) : rand_val(), 8'($urandom), 1'b0);
    for (int i = 0; i < NP; i++)
      send_beat(KIND_PRIOR, 11'(i), zeros ? val_t'(0) : rand_val(), 8'($urandom), 1'b0);
    for (int st = 0; st < NS; st++)
      for (int k = 0; k < 6; k++)
        send_beat(KIND_EMIT, 11'(st * NSYM + sym_pool[k]), zeros ? val_t'(0) : rand_val(),
                  8'($urandom), 1'b0);
  endtask

  // Random table write, possibly out of range; emission writes stay harmless
  task automatic noise_write();
    case ($urandom_range(2))
      0: send_beat(KIND_TRANS, 11'($urandom_range(1023)), rand_val(), 8'($urandom), 1'($urandom));
      1: send_beat(KIND_PRIOR, ($urandom_range(3) == 0) ? 11'h7ff : 11'($urandom_range(127)),
                   rand_val(), 8'($urandom), 1'($urandom));
      default: send_beat(KIND_EMIT, 11'($urandom_range(2047)), rand_val(), 8'($urandom),
                         1'($urandom));
    endcase
  endtask

  task automatic send_sequence(int len, ref int nsym);
    for (int p = 0; p < len; p++) begin
      if ($urandom_range(99) < 15) noise_write();
      send_beat(KIND_SYM, 11'($urandom), val_t'($urandom), pool_sym(), p == len - 1);
      nsym++;
    end
  endtask

  // Result side: check on the rising edge, choose ready on the falling edge
  always begin
    path_beat_t exp_b;
    @(posedge clk);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (path_q.size() == 0) begin
        $error("unexpected path beat: state %0d last %0d status %0d",
               out_ch.path_state, out_ch.path_last, out_ch.status);
        errors++;
      end else begin
        exp_b = path_q.pop_front();
        if (out_ch.path_state !== exp_b.st) begin
          $error("path_state expected %0d actual %0d", exp_b.st, out_ch.path_state);
          errors++;
        end
        if (out_ch.path_last !== exp_b.lst) begin
          $error("path_last expected %0d actual %0d", exp_b.lst, out_ch.path_last);
          errors++;
        end
        if (out_ch.status !== exp_b.stat) begin
          $error("status expected %0d actual %0d", exp_b.stat, out_ch.status);
          errors++;
        end
      end
    end
    @(negedge clk);
    // The long stall starts once the path is on offer
    if (hold_req && out_ch.valid) begin
      hold_req = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    #15ms;
    $display("second_order_hmm_viterbi: mismatch");
    $finish;
  end

  initial begin
    dir_row_t rows [$];
    int nsym;
    int len;
    bit held;
    bit drained;
    errors = 0;
    seq_pos = 0;
    first_sym = '0;
    hold_req = 1'b0;
    hold_left = 0;
    held = 1'b0;
    drained = 1'b0;
    tx_idle = 28;
    rx_idle = 69;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_TRANS;
    in_ch.table_index = '0;
    in_ch.log_value = '0;
    in_ch.symbol = '0;
    in_ch.seq_last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // All-zero tables first: every comparison ties, index 0 must win
    load_tables(1);

    // Directed: extreme values and addresses, short and minimal sequences
    rows = '{
      '{KIND_SYM,   11'd0,    16'sd0,      8'd255,  1'b1, 1, '{3'd0, 1'b1, STATUS_SHORT}},
      '{KIND_SYM,   11'd0,    16'sd0,      8'd0,    1'b0, 0, '{0, 0, 0}},
      '{KIND_SYM,   11'd0,    16'sd0,      8'd255,  1'b1, 0, '{0, 0, 0}},
      '{KIND_SYM,   11'd0,    16'sd0,      8'h55,   1'b0, 0, '{0, 0, 0}},
      '{KIND_SYM,   11'd0,    16'sd0,      8'haa,   1'b0, 0, '{0, 0, 0}},
      '{KIND_SYM,   11'd0,    16'sd0,      8'd0,    1'b1, 0, '{0, 0, 0}},
      '{KIND_TRANS, 11'd511,  16'sd32767,  8'd0,    1'b0, 0, '{0, 0, 0}},
      '{KIND_TRANS, 11'd512,  -16'sd5,     8'd0,    1'b0, 0, '{0, 0, 0}},
      '{KIND_TRANS, 11'h7ff,  16'sd1,      8'd0,    1'b1, 0, '{0, 0, 0}},
      '{KIND_TRANS, 11'd0,    VAL_ZERO,    8'd0,    1'b0, 0, '{0, 0, 0}},
      '{KIND_PRIOR, 11'd63,   VAL_ZERO,    8'd0,    1'b0, 0, '{0, 0, 0}},
      '{KIND_PRIOR, 11'd0,    -16'sd32767, 8'd0,    1'b0, 0, '{0, 0, 0}},
      '{KIND_PRIOR, 11'd64,   16'sd9,      8'd0,    1'b0, 0, '{0, 0, 0}},
      '{KIND_EMIT,  11'd2047, VAL_ZERO,    8'd0,    1'b0, 0, '{0, 0, 0}},
      '{KIND_EMIT,  11'd1,    16'sd32767,  8'd0,    1'b0, 0, '{0, 0, 0}},
      '{KIND_EMIT,  11'd255,  16'sd256,    8'd0,    1'b0, 0, '{0, 0, 0}},
      '{KIND_SYM,   11'd0,    16'sd0,      8'd1,    1'b0, 0, '{0, 0, 0}},
      '{KIND_SYM,   11'd0,    16'sd0,      8'd255,  1'b0, 0, '{0, 0, 0}},
      '{KIND_SYM,   11'd0,    16'sd0,      8'd1,    1'b0, 0, '{0, 0, 0}},
      '{KIND_SYM,   11'd0,    16'sd0,      8'd2,    1'b1, 0, '{0, 0, 0}}
    };
    foreach (rows[r])
      send_beat(rows[r].kind, rows[r].idx, rows[r].val, rows[r].sym, rows[r].last,
                rows[r].typed, rows[r].want);

    // Overlong sequence: the tail is dropped and the path is flagged truncated
    nsym = 0;
    for (int p = 0; p < MAXL + 2; p++)
      send_beat(KIND_SYM, 11'd0, 16'sd0, pool_sym(), p == MAXL + 1);

    // Random tables, then random sequences
    load_tables(0);
    while (nsym < 320) begin
      if (nsym < 110) begin
        tx_idle = 28; rx_idle = 69;
      end else if (nsym < 220) begin
        tx_idle = 69; rx_idle = 28;
      end else begin
        tx_idle = 0; rx_idle = 0;
      end
      case ($urandom_range(19))
        0, 1: len = 1;
        2: len = $urandom_range(60, 70);
        3, 4, 5: len = $urandom_range(9, 30);
        default: len = $urandom_range(2, 8);
      endcase
      // Long receiver stall while a long sequence and its successor queue up
      if (!held && nsym >= 60) begin
        held = 1'b1;
        hold_req = 1'b1;
        len = 40;
      end
      // Sender waits for the pipeline to drain once
      if (!drained && nsym >= 150) begin
        drained = 1'b1;
        wait (path_q.size() == 0);
      end
      if ($urandom_range(9) == 0) noise_write();
      send_sequence(len, nsym);
    end
    in_ch.valid = 1'b0;

    wait (path_q.size() == 0);
    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("second_order_hmm_viterbi: match");
    end else begin
      $display("second_order_hmm_viterbi: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/hmv_pkg.sv
rtl/hmv_if.sv
rtl/hmv_acs.sv
rtl/second_order_hmm_viterbi.sv
bench/testbench.sv
